>>> design/kgm_pkg.sv
// Types and constants shared by the key grab match table.
package kgm_pkg;

    localparam logic [1:0] FUNC_GRAB   = 2'd0;
    localparam logic [1:0] FUNC_UNGRAB = 2'd1;
    localparam logic [1:0] FUNC_FIND   = 2'd2;

    localparam logic [7:0]  ANY_KEY  = 8'h00;
    localparam logic [15:0] ANY_MODS = 16'h8000;

    localparam int unsigned RCW = 5;
    localparam logic [RCW-1:0] REMOVED_MAX = 5'd31;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  key_code;
        logic [15:0] modifier_mask;
        logic [31:0] window_id;
    } req_t;

    typedef struct packed {
        logic           status;
        logic [31:0]    found_window;
        logic [RCW-1:0] removed_count;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  key;
        logic [15:0] mods;
        logic [31:0] win;
    } entry_t;

endpackage

>>> design/kgm_match.sv
// Shared entry compare unit: ungrab and find matching rules.
module kgm_match (
    input  kgm_pkg::entry_t entry,
    input  kgm_pkg::req_t   req,
    input  logic            find_mode,
    output logic            hit
);

    logic key_eq;
    logic mods_eq;
    logic ungrab_hit;
    logic find_hit;

    assign key_eq  = (entry.key == req.key_code);
    assign mods_eq = (entry.mods == req.modifier_mask);

    assign ungrab_hit = (entry.win == req.window_id)
                     && ((req.key_code == kgm_pkg::ANY_KEY) || key_eq)
                     && ((req.modifier_mask == kgm_pkg::ANY_MODS) || mods_eq);

    assign find_hit = ((entry.key == kgm_pkg::ANY_KEY) || key_eq)
                   && ((entry.mods == kgm_pkg::ANY_MODS) || mods_eq);

    assign hit = find_mode ? find_hit : ungrab_hit;

endmodule

>>> design/key_grab_match_table_unit.sv
// Top level of the key grab match table: sequencer, entry memory and result register.
// The table holds up to TABLE_DEPTH grabs in age order in a single-port-write,
// registered-read memory. A grab word goes straight from acceptance to the done state.
// An ungrab walks every stored entry through one compare unit, compacting the
// survivors in place; on an empty table it goes straight to the done state.
// A find walks from the newest entry down and stops at the first hit, or goes
// straight to the done state on an empty table. One word is worked on at a time;
// req_ready is high only while the sequencer is idle, and a finished result waits
// in the output register while the next word is accepted. The done state of a
// word holds while an earlier result still waits there and rsp_ready is low.
// Reset empties the table at once.
module key_grab_match_table_unit #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  kgm_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output kgm_pkg::rsp_t   rsp
);

    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [CW-1:0]           left_reg, left_next;
    logic [CW-1:0]           wptr_reg, wptr_next;
    logic [IW-1:0]           idx_reg, idx_next;
    logic                    qv_reg, qv_next;
    logic [kgm_pkg::RCW-1:0] gone_reg, gone_next;
    logic                    st_reg, st_next;
    logic [31:0]             fw_reg, fw_next;
    kgm_pkg::req_t           req_reg, req_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    kgm_pkg::rsp_t           rsp_reg, rsp_next;

    kgm_pkg::entry_t         mem [TABLE_DEPTH];
    kgm_pkg::entry_t         mem_q;
    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    kgm_pkg::entry_t         wr_data;

    logic                    hit;
    logic                    find_mode;
    logic [CW-1:0]           cnt_dec;
    logic [CW-1:0]           wptr_after;

    assign find_mode  = (req_reg.func == kgm_pkg::FUNC_FIND);
    assign cnt_dec    = cnt_reg - CW'(1);
    assign wptr_after = hit ? wptr_reg : wptr_reg + CW'(1);

    kgm_match u_match (
        .entry     (mem_q),
        .req       (req_reg),
        .find_mode (find_mode),
        .hit       (hit)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q <= mem[idx_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        wptr_next      = wptr_reg;
        idx_next       = idx_reg;
        qv_next        = 1'b0;
        gone_next      = gone_reg;
        st_next        = st_reg;
        fw_next        = fw_reg;
        req_next       = req_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        req_ready      = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg[IW-1:0];
        wr_data        = '{key: req.key_code, mods: req.modifier_mask, win: req.window_id};

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next  = req;
                    st_next   = 1'b0;
                    fw_next   = '0;
                    gone_next = '0;
                    wptr_next = '0;
                    left_next = cnt_reg;
                    state_next = S_DONE;
                    unique case (req.func)
                        kgm_pkg::FUNC_GRAB:
                        begin
                            if (cnt_reg >= CW'(TABLE_DEPTH))
                            begin
                                st_next = 1'b1;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        kgm_pkg::FUNC_UNGRAB:
                        begin
                            idx_next = '0;
                            if (cnt_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        kgm_pkg::FUNC_FIND:
                        begin
                            idx_next = cnt_dec[IW-1:0];
                            if (cnt_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // issue the next read
                if (left_reg != '0)
                begin
                    qv_next   = 1'b1;
                    left_next = left_reg - CW'(1);
                    if (left_reg > CW'(1))
                    begin
                        idx_next = find_mode ? idx_reg - IW'(1) : idx_reg + IW'(1);
                    end
                end
                // evaluate the entry read last cycle
                if (qv_reg)
                begin
                    if (find_mode)
                    begin
                        if (hit)
                        begin
                            fw_next    = mem_q.win;
                            qv_next    = 1'b0;
                            state_next = S_DONE;
                        end
                        else if (left_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        if (hit)
                        begin
                            if (gone_reg != kgm_pkg::REMOVED_MAX)
                            begin
                                gone_next = gone_reg + kgm_pkg::RCW'(1);
                            end
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = wptr_reg[IW-1:0];
                            wr_data = mem_q;
                        end
                        wptr_next = wptr_after;
                        if (left_reg == '0)
                        begin
                            cnt_next   = wptr_after;
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.status        = st_reg;
                    rsp_next.found_window  = fw_reg;
                    rsp_next.removed_count = gone_reg;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            left_reg      <= '0;
            wptr_reg      <= '0;
            idx_reg       <= '0;
            qv_reg        <= 1'b0;
            gone_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            wptr_reg      <= wptr_next;
            idx_reg       <= idx_next;
            qv_reg        <= qv_next;
            gone_reg      <= gone_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg  <= st_next;
        fw_reg  <= fw_next;
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_grab_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req.func == kgm_pkg::FUNC_GRAB)
            && (cnt_reg < CW'(TABLE_DEPTH)))
        |=> (cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("accepted grab did not add an entry");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status)
        |-> ((rsp.found_window == '0) && (rsp.removed_count == '0)))
        else $error("rejected grab word carries find or ungrab data");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("second word accepted before the first finished");
`endif

endmodule
